>>> sv/pps_pkg.sv
// Shared constants, types and the constant divider for the positional PID step.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pps_pkg;

    localparam int IN_W   = 32;
    localparam int ERR_W  = 33;
    localparam int DIFF_W = 34;
    localparam int MAG_W  = 33;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;
    localparam int TERM_W = 45;
    localparam int SUM_W  = 47;
    localparam int NUM_LD = 6;

    localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [IDX_W-1:0] REG_INT_HI = 3'd3;
    localparam logic [IDX_W-1:0] REG_INT_LO = 3'd4;
    localparam logic [IDX_W-1:0] REG_DRV_HI = 3'd5;
    localparam logic [IDX_W-1:0] REG_DRV_LO = 3'd6;

    localparam logic signed [CFG_W-1:0] BOUND_HI_RST = 16'sh7fff;
    localparam logic signed [CFG_W-1:0] BOUND_LO_RST = 16'sh8000;

    // floor(v / 100) for v < 2^31: exact with a 32-bit reciprocal and a shift of 38
    localparam int          DIV_CONST   = 100;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [31:0] RECIP_100   = 32'd2748779070;

    typedef struct packed {
        logic [NUM_LD-1:0] ld;
    } t_scale_ctl;

    function automatic logic [24:0] div100(input logic [30:0] v);
        logic [63:0] prod;
        prod = {33'd0, v} * {32'd0, RECIP_100};
        return prod[RECIP_SHIFT+24:RECIP_SHIFT];
    endfunction

endpackage

>>> sv/pps_if.sv
// Valid/ready channel interfaces: config writes, input words and result words.
// Depends on pps_pkg for field widths.
`timescale 1ns / 1ps

interface pps_cfg_if;
    import pps_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pps_in_if;
    import pps_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic signed [IN_W-1:0] target;
    logic signed [IN_W-1:0] measured;
    modport source (output valid, output op, output target, output measured, input ready);
    modport sink   (input valid, input op, input target, input measured, output ready);
endinterface

interface pps_out_if;
    import pps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [CFG_W-1:0] drive;
    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

>>> sv/pps_scale.sv
// Six-stage scaled product trunc(gain * x / 100), sign-magnitude, chunked divide by 100.
// Depends on pps_pkg (div100, t_scale_ctl); stage loads come from the top level.
`timescale 1ns / 1ps

module pps_scale (
    input  logic                              i_clk,
    input  pps_pkg::t_scale_ctl               i_ctl,
    input  logic signed [pps_pkg::CFG_W-1:0]  i_gain,
    input  logic signed [pps_pkg::DIFF_W-1:0] i_x,
    output logic signed [pps_pkg::TERM_W-1:0] o_term
);
    import pps_pkg::*;

    // stage A: magnitude
    logic [DIFF_W-1:0] n_abs;
    logic              r_a_sign;
    logic [MAG_W-1:0]  r_a_mag;

    // stage B: high chunk / 100
    logic [16:0] hi;
    logic [24:0] q_hi_full;
    logic [10:0] n_b_qhi;
    logic [16:0] hi_rem;
    logic        r_b_sign;
    logic [10:0] r_b_qhi;
    logic [22:0] r_b_v;

    // stage C: low chunk / 100
    logic [24:0] q_lo_full;
    logic [15:0] n_c_qlo;
    logic [22:0] lo_rem;
    logic        r_c_sign;
    logic [26:0] r_c_q;
    logic [6:0]  r_c_rem;

    // stage D: products with gain magnitude
    logic [CFG_W-1:0] n_gmag;
    logic [42:0]      n_d_pq;
    logic [22:0]      n_d_pr;
    logic             r_d_neg;
    logic [42:0]      r_d_pq;
    logic [22:0]      r_d_pr;

    // stage E: remainder product / 100
    logic [24:0] prq_full;
    logic        r_e_neg;
    logic [42:0] r_e_pq;
    logic [15:0] r_e_prq;

    // stage F: signed term
    logic [43:0]              n_tmag;
    logic signed [TERM_W-1:0] n_term;
    logic signed [TERM_W-1:0] r_f_term;

    assign n_abs = i_x[DIFF_W-1] ? DIFF_W'(-i_x) : DIFF_W'(i_x);

    assign hi        = r_a_mag[MAG_W-1:16];
    assign q_hi_full = div100({14'd0, hi});
    assign n_b_qhi   = q_hi_full[10:0];
    assign hi_rem    = hi - 17'(n_b_qhi) * 17'(DIV_CONST);

    assign q_lo_full = div100({8'd0, r_b_v});
    assign n_c_qlo   = q_lo_full[15:0];
    assign lo_rem    = r_b_v - 23'(n_c_qlo) * 23'(DIV_CONST);

    assign n_gmag = i_gain[CFG_W-1] ? CFG_W'(-i_gain) : CFG_W'(i_gain);
    assign n_d_pq = 43'(n_gmag) * 43'(r_c_q);
    assign n_d_pr = 23'(n_gmag) * 23'(r_c_rem);

    assign prq_full = div100({8'd0, r_d_pr});

    assign n_tmag = 44'(r_e_pq) + 44'(r_e_prq);
    assign n_term = r_e_neg ? -$signed({1'b0, n_tmag}) : $signed({1'b0, n_tmag});

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[0]) begin
            r_a_sign <= i_x[DIFF_W-1];
            r_a_mag  <= n_abs[MAG_W-1:0];
        end
        if (i_ctl.ld[1]) begin
            r_b_sign <= r_a_sign;
            r_b_qhi  <= n_b_qhi;
            r_b_v    <= {hi_rem[6:0], r_a_mag[15:0]};
        end
        if (i_ctl.ld[2]) begin
            r_c_sign <= r_b_sign;
            r_c_q    <= {r_b_qhi, n_c_qlo};
            r_c_rem  <= lo_rem[6:0];
        end
        if (i_ctl.ld[3]) begin
            r_d_neg <= r_c_sign ^ i_gain[CFG_W-1];
            r_d_pq  <= n_d_pq;
            r_d_pr  <= n_d_pr;
        end
        if (i_ctl.ld[4]) begin
            r_e_neg <= r_d_neg;
            r_e_pq  <= r_d_pq;
            r_e_prq <= prq_full[15:0];
        end
        if (i_ctl.ld[5]) begin
            r_f_term <= n_term;
        end
    end

    assign o_term = r_f_term;

endmodule

>>> sv/positional_pid_step.sv
// Positional PID step: eleven-stage pipeline, one word accepted per cycle when unstalled.
// A compute word passes through the stage registers 1 to 11 in order before it shows at the output.
// Throughput: 1 word per cycle while o_out.ready holds; the error/accumulator update in stage 2 is the only loop.
// Clear words update state in stage 2 and leave the pipeline there without a result.
// Reset (sync, active low) empties the pipeline, zeroes state and restores register defaults.
`timescale 1ns / 1ps

module positional_pid_step (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_cfg_if.sink   i_cfg,
    pps_in_if.sink    i_in,
    pps_out_if.source o_out
);
    import pps_pkg::*;

    localparam int LAST = 11;

    logic [LAST:1]   r_vld;
    logic [LAST+1:1] rdy;

    logic signed [CFG_W-1:0] r_gain_p;
    logic signed [CFG_W-1:0] r_gain_i;
    logic signed [CFG_W-1:0] r_gain_d;
    logic signed [CFG_W-1:0] r_int_hi;
    logic signed [CFG_W-1:0] r_int_lo;
    logic signed [CFG_W-1:0] r_drv_hi;
    logic signed [CFG_W-1:0] r_drv_lo;

    logic                   r_s1_op;
    logic signed [IN_W-1:0] r_s1_target;
    logic signed [IN_W-1:0] r_s1_measured;
    logic signed [ERR_W-1:0] n_err;

    logic                     r_s2_op;
    logic signed [ERR_W-1:0]  r_s2_err;
    logic signed [DIFF_W-1:0] n_acc_sum;
    logic signed [CFG_W-1:0]  n_acc;
    logic signed [DIFF_W-1:0] n_diff;

    logic signed [CFG_W-1:0] r_acc;
    logic signed [ERR_W-1:0] r_last_err;

    logic signed [DIFF_W-1:0] r_s3_xp;
    logic signed [DIFF_W-1:0] r_s3_xi;
    logic signed [DIFF_W-1:0] r_s3_xd;

    t_scale_ctl               scale_ctl;
    logic signed [TERM_W-1:0] term_p;
    logic signed [TERM_W-1:0] term_i;
    logic signed [TERM_W-1:0] term_d;

    logic signed [SUM_W-1:0] r_sum;
    logic signed [CFG_W-1:0] n_drive;
    logic signed [CFG_W-1:0] r_drive;

    // ready ripples back from the output: a stage loads when empty or moving on
    always_comb begin
        rdy[LAST+1] = o_out.ready;
        for (int k = LAST; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign i_in.ready  = rdy[1];
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_int_hi <= BOUND_HI_RST;
            r_int_lo <= BOUND_LO_RST;
            r_drv_hi <= BOUND_HI_RST;
            r_drv_lo <= BOUND_LO_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_GAIN_P: r_gain_p <= $signed(i_cfg.data);
                REG_GAIN_I: r_gain_i <= $signed(i_cfg.data);
                REG_GAIN_D: r_gain_d <= $signed(i_cfg.data);
                REG_INT_HI: r_int_hi <= $signed(i_cfg.data);
                REG_INT_LO: r_int_lo <= $signed(i_cfg.data);
                REG_DRV_HI: r_drv_hi <= $signed(i_cfg.data);
                REG_DRV_LO: r_drv_lo <= $signed(i_cfg.data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[1]) r_vld[1] <= i_in.valid;
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2] && !r_s2_op;
            for (int k = 4; k <= LAST; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: input word
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_op       <= i_in.op;
            r_s1_target   <= i_in.target;
            r_s1_measured <= i_in.measured;
        end
    end

    assign n_err = $signed({r_s1_target[IN_W-1], r_s1_target})
                 - $signed({r_s1_measured[IN_W-1], r_s1_measured});

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_op  <= r_s1_op;
            r_s2_err <= n_err;
        end
    end

    // stage 2: accumulator and derivative against the stored state
    assign n_acc_sum = DIFF_W'(r_acc) + DIFF_W'(r_s2_err);
    assign n_diff    = DIFF_W'(r_s2_err) - DIFF_W'(r_last_err);

    always_comb begin
        if (n_acc_sum > DIFF_W'(r_int_hi)) begin
            n_acc = r_int_hi;
        end else if (n_acc_sum < DIFF_W'(r_int_lo)) begin
            n_acc = r_int_lo;
        end else begin
            n_acc = $signed(n_acc_sum[CFG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_last_err <= '0;
        end else if (r_vld[2] && rdy[3]) begin
            if (r_s2_op) begin
                r_acc      <= '0;
                r_last_err <= '0;
            end else begin
                r_acc      <= n_acc;
                r_last_err <= r_s2_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_xp <= DIFF_W'(r_s2_err);
            r_s3_xi <= DIFF_W'(n_acc);
            r_s3_xd <= n_diff;
        end
    end

    // stages 4 to 9: the three scaled terms
    assign scale_ctl.ld = rdy[9:4];

    pps_scale u_scale_p (
        .i_clk  (i_clk),
        .i_ctl  (scale_ctl),
        .i_gain (r_gain_p),
        .i_x    (r_s3_xp),
        .o_term (term_p)
    );

    pps_scale u_scale_i (
        .i_clk  (i_clk),
        .i_ctl  (scale_ctl),
        .i_gain (r_gain_i),
        .i_x    (r_s3_xi),
        .o_term (term_i)
    );

    pps_scale u_scale_d (
        .i_clk  (i_clk),
        .i_ctl  (scale_ctl),
        .i_gain (r_gain_d),
        .i_x    (r_s3_xd),
        .o_term (term_d)
    );

    // stage 10: sum; stage 11: clamp into the output register
    always_ff @(posedge i_clk) begin
        if (rdy[10]) begin
            r_sum <= SUM_W'(term_p) + SUM_W'(term_i) + SUM_W'(term_d);
        end
    end

    always_comb begin
        if (r_sum > SUM_W'(r_drv_hi)) begin
            n_drive = r_drv_hi;
        end else if (r_sum < SUM_W'(r_drv_lo)) begin
            n_drive = r_drv_lo;
        end else begin
            n_drive = $signed(r_sum[CFG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[11]) begin
            r_drive <= n_drive;
        end
    end

    assign o_out.valid = r_vld[LAST];
    assign o_out.drive = r_drive;

    a_clear_zeroes_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && r_s2_op && rdy[3]) |=> (r_acc == '0 && r_last_err == '0))
        else $error("clear word did not zero the state");

    a_acc_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !r_s2_op && rdy[3] && (r_int_lo <= r_int_hi))
        |=> (r_acc <= $past(r_int_hi) && r_acc >= $past(r_int_lo)))
        else $error("accumulator outside its bounds");

    a_drive_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[10] && rdy[11] && (r_drv_lo <= r_drv_hi))
        |=> (r_drive <= $past(r_drv_hi) && r_drive >= $past(r_drv_lo)))
        else $error("drive outside its bounds");

    a_sum_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[10] && !rdy[10]) |=> (r_vld[10] && $stable(r_sum)))
        else $error("stalled sum word lost or changed");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for positional_pid_step: config writes, directed and random words.
// A class predicts each drive word and checks it; needs pps_pkg, pps_if and the block.
`timescale 1ns / 1ps

module testbench;
    import pps_pkg::*;

    localparam logic             OP_STEP    = 1'b0;
    localparam logic             OP_CLEAR   = 1'b1;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int               LATENCY    = 11;
    localparam int               DRAIN_MAX  = 4000;

    class drive_tracker;
        logic signed [CFG_W-1:0] cfg_reg [0:6];
        longint                  prev_err;
        longint                  acc;
        logic signed [CFG_W-1:0] pending_drive [$];
        int                      errors;

        function new();
            cfg_reg[REG_GAIN_P] = '0;
            cfg_reg[REG_GAIN_I] = '0;
            cfg_reg[REG_GAIN_D] = '0;
            cfg_reg[REG_INT_HI] = BOUND_HI_RST;
            cfg_reg[REG_INT_LO] = BOUND_LO_RST;
            cfg_reg[REG_DRV_HI] = BOUND_HI_RST;
            cfg_reg[REG_DRV_LO] = BOUND_LO_RST;
            prev_err = 0;
            acc      = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            if (idx <= REG_DRV_LO)
                cfg_reg[idx] = value;
        endfunction

        // when the bounds are crossed, the upper bound wins for values above it and the lower bound for all others
        function longint clamp_hi_lo(longint x, longint hi, longint lo);
            if (x > hi)
                return hi;
            if (x < lo)
                return lo;
            return x;
        endfunction

        function void note_word(logic op, logic signed [IN_W-1:0] tgt,
                                logic signed [IN_W-1:0] meas);
            longint err;
            longint drv;
            if (op == OP_CLEAR) begin
                prev_err = 0;
                acc      = 0;
                return;
            end
            err = longint'(tgt) - longint'(meas);
            acc = clamp_hi_lo(acc + err, cfg_reg[REG_INT_HI], cfg_reg[REG_INT_LO]);
            drv = (longint'(cfg_reg[REG_GAIN_P]) * err) / DIV_CONST;
            drv += (longint'(cfg_reg[REG_GAIN_I]) * acc) / DIV_CONST;
            drv += (longint'(cfg_reg[REG_GAIN_D]) * (err - prev_err)) / DIV_CONST;
            drv = clamp_hi_lo(drv, cfg_reg[REG_DRV_HI], cfg_reg[REG_DRV_LO]);
            prev_err = err;
            pending_drive.push_back(drv[CFG_W-1:0]);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_drive(logic signed [CFG_W-1:0] got);
            logic signed [CFG_W-1:0] want;
            if (pending_drive.size() == 0) begin
                report($sformatf("drive %0d with no word outstanding", got));
            end else begin
                want = pending_drive.pop_front();
                if (got !== want)
                    report($sformatf("drive %0d, expected %0d", got, want));
            end
        endtask

        task flush_missing();
            while (pending_drive.size() != 0)
                report($sformatf("drive %0d never arrived", pending_drive.pop_front()));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;

    drive_tracker board = new();

    pps_cfg_if cfg_bus ();
    pps_in_if  in_bus ();
    pps_out_if out_bus ();

    positional_pid_step u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        out_bus.ready <= steady || ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            board.check_drive(out_bus.drive);
    end

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] gp, gi, gd, ihi, ilo, dhi, dlo);
        cfg_write(REG_GAIN_P, gp);
        cfg_write(REG_GAIN_I, gi);
        cfg_write(REG_GAIN_D, gd);
        cfg_write(REG_INT_HI, ihi);
        cfg_write(REG_INT_LO, ilo);
        cfg_write(REG_DRV_HI, dhi);
        cfg_write(REG_DRV_LO, dlo);
    endtask

    task automatic send_word(input logic op, input logic signed [IN_W-1:0] tgt,
                             input logic signed [IN_W-1:0] meas);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 12) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.op       <= op;
        in_bus.target   <= tgt;
        in_bus.measured <= meas;
        do @(posedge i_clk); while (!in_bus.ready);
        board.note_word(op, tgt, meas);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (board.pending_drive.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        board.flush_missing();
    endtask

    // clear words leave no result, so let the pipeline empty before touching registers
    task automatic settle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [IN_W-1:0] pick_level();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return $urandom_range(4000) - 2000;
            5, 6:    return $urandom_range(2097152) - 1048576;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [CFG_W-1:0] pick_reg();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            4, 5:    return CFG_W'($urandom_range(600) - 300);
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        logic signed [CFG_W-1:0] ihi, ilo, dhi, dlo, t;
        ihi = pick_reg();
        ilo = pick_reg();
        dhi = pick_reg();
        dlo = pick_reg();
        if ($urandom_range(2) != 0 && ihi < ilo) begin
            t = ihi; ihi = ilo; ilo = t;
        end
        if ($urandom_range(2) != 0 && dhi < dlo) begin
            t = dhi; dhi = dlo; dlo = t;
        end
        configure(pick_reg(), pick_reg(), pick_reg(), ihi, ilo, dhi, dlo);
        if ($urandom_range(3) == 0)
            cfg_write(REG_UNUSED, CFG_W'($urandom));
    endtask

    task automatic random_word();
        logic                    op;
        logic signed [IN_W-1:0]  tgt, meas;
        op  = ($urandom_range(99) < 4) ? OP_CLEAR : OP_STEP;
        tgt = pick_level();
        if ($urandom_range(1))
            meas = tgt + $urandom_range(400) - 200;
        else
            meas = pick_level();
        send_word(op, tgt, meas);
    endtask

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int phase, n;
        i_rst_n          <= 1'b0;
        cfg_bus.valid    <= 1'b0;
        cfg_bus.index    <= '0;
        cfg_bus.data     <= '0;
        in_bus.valid     <= 1'b0;
        in_bus.op        <= OP_STEP;
        in_bus.target    <= '0;
        in_bus.measured  <= '0;
        steady = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults after reset
        send_word(OP_STEP, 32'sd1000, -32'sd5);
        send_word(OP_CLEAR, 32'sd7, 32'sd3);
        settle();

        configure(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_word(OP_STEP, 32'sh7fff_ffff, 32'sh8000_0000);
        send_word(OP_STEP, 32'sh7fff_ffff, 32'sh8000_0000);
        send_word(OP_STEP, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(OP_STEP, 32'sd0, 32'sd0);
        send_word(OP_CLEAR, 32'sh8000_0000, 32'sh7fff_ffff);
        send_word(OP_STEP, 32'sd123, -32'sd456);
        settle();

        configure(16'sh8000, 16'sh8000, 16'sh8000, 16'sd100, -16'sd100, 16'sd250, -16'sd250);
        send_word(OP_STEP, 32'sd50, 32'sd0);
        send_word(OP_STEP, 32'sd50, 32'sd0);
        send_word(OP_STEP, 32'sd50, 32'sd0);
        send_word(OP_STEP, -32'sd300, 32'sd0);
        send_word(OP_CLEAR, 32'sd0, 32'sd0);
        send_word(OP_STEP, 32'sh8000_0000, 32'sh7fff_ffff);
        settle();

        // crossed integral and drive bounds, then an out-of-range index
        configure(16'sd100, 16'sd100, -16'sd100, -16'sd10, 16'sd10, -16'sd20, 16'sd20);
        cfg_write(REG_UNUSED, 16'h1234);
        send_word(OP_STEP, 32'sd5, 32'sd0);
        send_word(OP_STEP, -32'sd50, 32'sd0);
        send_word(OP_STEP, 32'sd100, 32'sd0);
        send_word(OP_STEP, 32'sd0, 32'sd0);
        send_word(OP_STEP, -32'sd1, -32'sd1);
        settle();

        for (phase = 0; phase < 10; phase++) begin
            steady = (phase == 3);
            randomize_config();
            for (n = 0; n < 125; n++) begin
                if (phase == 6 && n == 60) begin
                    @(negedge i_clk);
                    in_bus.valid <= 1'b0;
                    drain();
                end
                random_word();
            end
            settle();
        end
        steady = 1'b0;

        repeat (LATENCY + 8) @(posedge i_clk);
        board.flush_missing();
        if (board.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
